@@ rtl/core/tld_pkg.sv @@
// Shared constants, command codes and types for the telnet line discipline.
package tld_pkg;

  localparam int LINE_DEPTH   = 64;
  localparam int LEN_W        = $clog2(LINE_DEPTH);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

  localparam logic [LEN_W-1:0] LINE_LIMIT = LEN_W'(LINE_DEPTH - 3);

  localparam logic [7:0] CH_IAC  = 8'd255;
  localparam logic [7:0] CH_WILL = 8'd251;
  localparam logic [7:0] CH_DONT = 8'd254;
  localparam logic [7:0] CH_DEL  = 8'd127;
  localparam logic [7:0] CH_SP   = 8'd32;
  localparam logic [7:0] CH_TILDE = 8'd126;
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_BS   = 8'd8;

  localparam logic [1:0] OP_ECHO  = 2'd0;
  localparam logic [1:0] OP_ERASE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } tld_cmd_t;

endpackage

@@ rtl/core/tld_ram.sv @@
// Generic single-port-write, registered-read RAM.
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/tld_front.sv @@
// Front end: IAC stripping and classification of received bytes into commands.
module tld_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      in_rx_byte,
  input  logic            push,
  output logic            full,
  input  logic            q_full,
  output logic            cmd_push,
  output tld_pkg::tld_cmd_t cmd
);

  import tld_pkg::*;

  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_CMD  = 2'd1;
  localparam logic [1:0] MODE_OPT  = 2'd2;

  logic [1:0] mode_r, mode_nxt;
  logic       accept;
  logic       has_cmd;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    mode_nxt = mode_r;
    has_cmd  = 1'b0;
    cmd.op   = OP_ECHO;
    cmd.data = in_rx_byte;
    case (mode_r)
      MODE_OPT: begin
        mode_nxt = MODE_TEXT;
      end
      MODE_CMD: begin
        mode_nxt = (in_rx_byte inside {[CH_WILL:CH_DONT]}) ? MODE_OPT : MODE_TEXT;
      end
      default: begin
        mode_nxt = MODE_TEXT;
        if (in_rx_byte == CH_IAC) begin
          mode_nxt = MODE_CMD;
        end else if (in_rx_byte inside {CH_CR, CH_LF}) begin
          has_cmd = 1'b1;
          cmd.op  = OP_FLUSH;
        end else if (in_rx_byte inside {CH_BS, CH_DEL}) begin
          has_cmd = 1'b1;
          cmd.op  = OP_ERASE;
        end else if (in_rx_byte inside {[CH_SP:CH_TILDE]}) begin
          has_cmd = 1'b1;
          cmd.op  = OP_ECHO;
        end
      end
    endcase
  end

  assign cmd_push = accept && has_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TEXT;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

@@ rtl/core/tld_cmd_queue.sv @@
// Short command queue between the front end and the line editor.
module tld_cmd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  tld_pkg::tld_cmd_t wr_cmd,
  output logic              q_full,
  input  logic              rd_en,
  output tld_pkg::tld_cmd_t rd_cmd,
  output logic              q_empty
);

  import tld_pkg::*;

  tld_cmd_t               entries_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_PTR_W:0]   count_r;
  logic                   do_wr, do_rd;

  assign q_full  = (count_r == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_cmd  = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/tld_back.sv @@
// Line editor: owns the line store and length, sequences echo and shell words.
module tld_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tld_pkg::tld_cmd_t cmd,
  input  logic              q_empty,
  output logic              cmd_pop,
  output logic              empty,
  input  logic              pop,
  output logic              out_dest,
  output logic [7:0]        out_byte,
  output logic              out_last_of_run
);

  import tld_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SP   = 3'd1;
  localparam logic [2:0] ST_BS2  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_DATA = 3'd4;
  localparam logic [2:0] ST_CR   = 3'd5;
  localparam logic [2:0] ST_LF   = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             valid_r;
  logic             dest_r, dest_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             last_r, last_nxt;
  logic             emit;
  logic             slot_free;
  logic             wr_en;
  logic [7:0]       rd_data;

  tld_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (len_r),
    .wr_data (cmd.data),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // the output word may be replaced in the cycle it is taken
  assign slot_free = !valid_r || pop;

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    emit      = 1'b0;
    dest_nxt  = 1'b0;
    byte_nxt  = CH_BS;
    last_nxt  = 1'b0;
    wr_en     = 1'b0;
    cmd_pop   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty && slot_free) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_ECHO: begin
              if (len_r < LINE_LIMIT) begin
                wr_en    = 1'b1;
                len_nxt  = len_r + 1'b1;
                emit     = 1'b1;
                byte_nxt = cmd.data;
                last_nxt = 1'b1;
              end
            end
            OP_ERASE: begin
              if (len_r != '0) begin
                len_nxt   = len_r - 1'b1;
                emit      = 1'b1;
                state_nxt = ST_SP;
              end
            end
            OP_FLUSH: begin
              idx_nxt = '0;
              if (len_r == '0) begin
                emit      = 1'b1;
                dest_nxt  = 1'b1;
                byte_nxt  = CH_CR;
                state_nxt = ST_LF;
              end else begin
                state_nxt = ST_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SP: begin
        if (slot_free) begin
          emit      = 1'b1;
          byte_nxt  = CH_SP;
          state_nxt = ST_BS2;
        end
      end
      ST_BS2: begin
        if (slot_free) begin
          emit      = 1'b1;
          last_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        // read address settles; data arrives next cycle
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        if (slot_free) begin
          emit     = 1'b1;
          dest_nxt = 1'b1;
          byte_nxt = rd_data;
          if (idx_r == LEN_W'(len_r - 1'b1)) begin
            state_nxt = ST_CR;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_CR: begin
        if (slot_free) begin
          emit      = 1'b1;
          dest_nxt  = 1'b1;
          byte_nxt  = CH_CR;
          state_nxt = ST_LF;
        end
      end
      ST_LF: begin
        if (slot_free) begin
          emit      = 1'b1;
          dest_nxt  = 1'b1;
          byte_nxt  = CH_LF;
          last_nxt  = 1'b1;
          len_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      if (emit) begin
        valid_r <= 1'b1;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dest_r <= dest_nxt;
      byte_r <= byte_nxt;
      last_r <= last_nxt;
    end
  end

  assign empty           = !valid_r;
  assign out_dest        = dest_r;
  assign out_byte        = byte_r;
  assign out_last_of_run = last_r;

endmodule

@@ rtl/core/telnet_line_discipline.sv @@
// Top level of the telnet line discipline: front end, command queue, line editor.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+----------------------------------
//  input   | in        | push / full        | in_rx_byte
//  result  | out       | empty / pop        | out_dest, out_byte, out_last_of_run
//
// The front end takes a byte every cycle while the command queue has room.
// The editor takes a new command only from idle: an echo stores the byte and
// registers it as the output word, an erase gives backspace, space, backspace,
// and a line end gives each stored byte, then CR and LF, through the line
// RAM's registered read (one read and one output word per byte).
// Reset clears the parse mode, queue, line length and output valid flag; the
// line RAM keeps its contents. A held result stalls the editor; the front end
// keeps taking bytes until the four-entry command queue fills.
module telnet_line_discipline (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_rx_byte,
  input  logic       push,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output logic       out_dest,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  import tld_pkg::*;

  tld_cmd_t front_cmd;
  tld_cmd_t queue_cmd;
  logic     cmd_push;
  logic     cmd_pop;
  logic     q_full;
  logic     q_empty;

  tld_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_rx_byte (in_rx_byte),
    .push       (push),
    .full       (full),
    .q_full     (q_full),
    .cmd_push   (cmd_push),
    .cmd        (front_cmd)
  );

  tld_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_cmd  (front_cmd),
    .q_full  (q_full),
    .rd_en   (cmd_pop),
    .rd_cmd  (queue_cmd),
    .q_empty (q_empty)
  );

  tld_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (queue_cmd),
    .q_empty         (q_empty),
    .cmd_pop         (cmd_pop),
    .empty           (empty),
    .pop             (pop),
    .out_dest        (out_dest),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule
